### sv/isle_pkg.sv
package isle_pkg;

	typedef enum logic [3:0] {
		MODE_PUSH       = 4'd0,
		MODE_APPEND     = 4'd1,
		MODE_INSERT_AT  = 4'd2,
		MODE_POP        = 4'd3,
		MODE_REMOVE_END = 4'd4,
		MODE_REMOVE_AT  = 4'd5,
		MODE_READ_AT    = 4'd6,
		MODE_SWAP       = 4'd7,
		MODE_CLEAR      = 4'd8,
		MODE_PEEK       = 4'd9
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_RANGE = 3'd2,
		ST_FULL  = 3'd3,
		ST_SWAP  = 3'd4
	} status_t;

	// What every cell of the row does at a clock edge
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INS,
		OP_DEL,
		OP_SWP
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     rd_en;
	} ctrl_t;

endpackage

### sv/indexed_stack_list_engine.sv
// Indexed list stack built as a row of DEPTH data cells, cell 0 holding the
// top of the list and cell count-1 the bottom. For each item taken, the
// control decode checks the operation against the entry count and broadcasts
// one command to the row, and in that same edge each cell either holds,
// takes its upper neighbor (insert, push, append), takes its lower neighbor
// (pop, remove), or takes a word from the swap buses. Reads use one selection
// bus and swaps use two. A result sits in an output register, and a new item
// is taken whenever that register is empty or is being drained in the same
// cycle, so the block sustains one item per clock while the consumer does not
// stall. Cells beyond the count hold stale words that are never returned.
module indexed_stack_list_engine #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32,
	localparam int IDX_W     = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [3:0]            mode,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [IDX_W-1:0]      index,
	input  logic [IDX_W-1:0]      second_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output isle_pkg::status_t     status,
	output logic [DATA_WIDTH-1:0] read_value,
	output logic [IDX_W-1:0]      count
);
	import isle_pkg::*;

	logic                  in_xfer;
	logic                  out_valid_q;
	logic [IDX_W-1:0]      count_q;
	status_t               status_q;
	logic [DATA_WIDTH-1:0] read_value_q;

	ctrl_t                 ctrl;
	status_t               st;
	logic [IDX_W-1:0]      pos;
	logic [IDX_W-1:0]      pos2;
	logic [IDX_W-1:0]      cnt_next;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] tap_a     [DEPTH];
	logic [DATA_WIDTH-1:0] tap_b     [DEPTH];
	logic [DATA_WIDTH-1:0] bus_a;
	logic [DATA_WIDTH-1:0] bus_b;

	// take a new item whenever the result register is free or drains now
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	isle_ctrl #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_ctrl (
		.go           (in_xfer),
		.mode         (mode),
		.index        (index),
		.second_index (second_index),
		.cnt          (count_q),
		.ctrl         (ctrl),
		.status       (st),
		.pos          (pos),
		.pos2         (pos2),
		.cnt_next     (cnt_next)
	);

	// row of cells; each cell sees its two neighbors and the swap buses
	for (genvar p = 0; p < DEPTH; p++) begin : g_cell
		logic [DATA_WIDTH-1:0] up_d;
		logic [DATA_WIDTH-1:0] dn_d;

		if (p == 0) begin : g_top
			assign up_d = '0;
		end else begin : g_up
			assign up_d = cell_data[p-1];
		end

		if (p == DEPTH - 1) begin : g_bot
			assign dn_d = cell_data[p];
		end else begin : g_dn
			assign dn_d = cell_data[p+1];
		end

		isle_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.IDX_W      (IDX_W),
			.POS        (p)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.pos     (pos),
			.pos2    (pos2),
			.value   (value),
			.bus_a   (bus_a),
			.bus_b   (bus_b),
			.up_data (up_d),
			.dn_data (dn_d),
			.data    (cell_data[p]),
			.tap_a   (tap_a[p]),
			.tap_b   (tap_b[p])
		);
	end

	// at most one cell drives each tap, so an OR merges the row
	always_comb begin
		bus_a = '0;
		bus_b = '0;
		for (int p = 0; p < DEPTH; p++) begin
			bus_a = bus_a | tap_a[p];
			bus_b = bus_b | tap_b[p];
		end
	end

	// control state: entry count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				count_q     <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload; hold while the consumer stalls
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			status_q     <= st;
			read_value_q <= (ctrl.rd_en && st == ST_OK) ? bus_a : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = count_q;

endmodule

### sv/isle_cell.sv
module isle_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int IDX_W      = 7,
	parameter int POS        = 0
) (
	input  logic                  clk,
	input  isle_pkg::ctrl_t       ctrl,
	input  logic [IDX_W-1:0]      pos,
	input  logic [IDX_W-1:0]      pos2,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] bus_a,
	input  logic [DATA_WIDTH-1:0] bus_b,
	input  logic [DATA_WIDTH-1:0] up_data,
	input  logic [DATA_WIDTH-1:0] dn_data,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] tap_a,
	output logic [DATA_WIDTH-1:0] tap_b
);
	import isle_pkg::*;

	localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  hit_a;
	logic                  hit_b;
	logic                  below_a;

	assign hit_a   = (pos == MY_POS);
	assign hit_b   = (pos2 == MY_POS);
	assign below_a = (MY_POS > pos);

	assign data  = data_q;
	assign tap_a = hit_a ? data_q : '0;
	assign tap_b = hit_b ? data_q : '0;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INS: begin
				// open a gap at pos: cells below take their upper neighbor
				if (below_a) begin
					data_q <= up_data;
				end else if (hit_a) begin
					data_q <= value;
				end
			end
			OP_DEL: begin
				// close the gap: cells from pos down take their lower neighbor
				if (below_a || hit_a) begin
					data_q <= dn_data;
				end
			end
			OP_SWP: begin
				if (hit_a) begin
					data_q <= bus_b;
				end else if (hit_b) begin
					data_q <= bus_a;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

### sv/isle_ctrl.sv
module isle_ctrl #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 7
) (
	input  logic                 go,
	input  logic [3:0]           mode,
	input  logic [IDX_W-1:0]     index,
	input  logic [IDX_W-1:0]     second_index,
	input  logic [IDX_W-1:0]     cnt,
	output isle_pkg::ctrl_t      ctrl,
	output isle_pkg::status_t    status,
	output logic [IDX_W-1:0]     pos,
	output logic [IDX_W-1:0]     pos2,
	output logic [IDX_W-1:0]     cnt_next
);
	import isle_pkg::*;

	localparam logic [IDX_W-1:0] FULL_CNT = IDX_W'(DEPTH);
	localparam logic [IDX_W-1:0] ONE      = IDX_W'(1);

	logic full;
	logic empty;

	assign full  = (cnt >= FULL_CNT);
	assign empty = (cnt == '0);

	always_comb begin
		ctrl.op    = OP_HOLD;
		ctrl.rd_en = 1'b0;
		status     = ST_OK;
		pos        = index;
		pos2       = second_index;
		cnt_next   = cnt;
		case (mode_t'(mode))
			MODE_PUSH: begin
				pos = '0;
				if (full) begin
					status = ST_FULL;
				end else begin
					ctrl.op  = OP_INS;
					cnt_next = cnt + ONE;
				end
			end
			MODE_APPEND: begin
				pos = cnt;
				if (full) begin
					status = ST_FULL;
				end else begin
					ctrl.op  = OP_INS;
					cnt_next = cnt + ONE;
				end
			end
			MODE_INSERT_AT: begin
				if (index > cnt) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					ctrl.op  = OP_INS;
					cnt_next = cnt + ONE;
				end
			end
			MODE_POP: begin
				pos = '0;
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctrl.op    = OP_DEL;
					ctrl.rd_en = 1'b1;
					cnt_next   = cnt - ONE;
				end
			end
			MODE_REMOVE_END: begin
				pos = cnt - ONE;
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctrl.op    = OP_DEL;
					ctrl.rd_en = 1'b1;
					cnt_next   = cnt - ONE;
				end
			end
			MODE_REMOVE_AT: begin
				if (index >= cnt) begin
					status = ST_RANGE;
				end else begin
					ctrl.op    = OP_DEL;
					ctrl.rd_en = 1'b1;
					cnt_next   = cnt - ONE;
				end
			end
			MODE_READ_AT: begin
				if (index >= cnt) begin
					status = ST_RANGE;
				end else begin
					ctrl.rd_en = 1'b1;
				end
			end
			MODE_SWAP: begin
				if (index >= cnt || second_index >= cnt || index == second_index) begin
					status = ST_SWAP;
				end else begin
					ctrl.op = OP_SWP;
				end
			end
			MODE_CLEAR: begin
				cnt_next = '0;
			end
			MODE_PEEK: begin
				pos = '0;
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctrl.rd_en = 1'b1;
				end
			end
			default: begin
				ctrl.op = OP_HOLD;
			end
		endcase
		// drop all cell activity when no item is taken this cycle
		if (!go) begin
			ctrl.op = OP_HOLD;
		end
	end

endmodule
